// ===== sv/command_frame_builder_fletcher8_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the command frame builder
// Shorthand for clocked assertions that are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_BUILDER_FLETCHER8_CORE_MACROS_SVH
`define COMMAND_FRAME_BUILDER_FLETCHER8_CORE_MACROS_SVH

// Same-cycle implication.
`define CFBF8_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cfbf8 same-cycle check failed");

// Next-cycle implication.
`define CFBF8_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cfbf8 next-cycle check failed");

`endif

// ===== sv/cfbf8_pkg.sv =====
// ----------------------------------------------------------------------------
// cfbf8_pkg
// Types and constants shared by the command frame builder modules.
// ----------------------------------------------------------------------------
package cfbf8_pkg;

   localparam int HDR_LEN      = 8;
   localparam int COUNT_W      = $clog2(HDR_LEN + 1);
   localparam int CSR_INDEX_W  = 8;

   localparam logic FUNC_START   = 1'b0;
   localparam logic FUNC_PAYLOAD = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_FIRST  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_SECOND = 8'd1;

   localparam logic [7:0] SYNC_FIRST_RESET  = 8'd72;
   localparam logic [7:0] SYNC_SECOND_RESET = 8'd101;
   localparam logic [7:0] LEN_HIGH_BYTE     = 8'h00;

   typedef struct packed {
      logic       in_payload;
      logic [7:0] bytes_remaining;
      logic [7:0] sum_low;
      logic [7:0] sum_high;
   } frame_state_type;

   // Bytes produced by one request; entry 0 leaves first.
   typedef struct packed {
      logic [HDR_LEN-1:0][7:0] data;
      logic [HDR_LEN-1:0]      ends;
      logic [COUNT_W-1:0]      count;
   } burst_type;

endpackage

// ===== sv/cfbf8_encode.sv =====
// ----------------------------------------------------------------------------
// cfbf8_encode
// Turns one request into its burst of frame bytes and the next frame state.
// ----------------------------------------------------------------------------
module cfbf8_encode import cfbf8_pkg::*; (
   input  logic            func,
   input  logic [7:0]      cmd_class,
   input  logic [7:0]      command_code,
   input  logic [7:0]      payload_len,
   input  logic [7:0]      payload_byte,
   input  logic [7:0]      sync_first,
   input  logic [7:0]      sync_second,
   input  frame_state_type state_cur,
   output frame_state_type state_next,
   output burst_type       burst
);

   logic [7:0] hdr_pair;
   logic [7:0] hdr_sum_a;
   logic [7:0] hdr_sum_b;
   logic [7:0] pay_sum_low;
   logic [7:0] pay_sum_high;
   logic [7:0] remaining_dec;

   // Header sums over type, code, zero and length, written out in closed form.
   assign hdr_pair  = cmd_class + command_code;
   assign hdr_sum_a = hdr_pair + payload_len;
   assign hdr_sum_b = cmd_class + hdr_pair + hdr_pair + hdr_sum_a;

   assign pay_sum_low   = state_cur.sum_low + payload_byte;
   assign pay_sum_high  = state_cur.sum_high + pay_sum_low;
   assign remaining_dec = state_cur.bytes_remaining - 8'd1;

   always_comb begin
      burst      = '0;
      state_next = state_cur;
      if (func == FUNC_START) begin
         burst.data[0] = sync_first;
         burst.data[1] = sync_second;
         burst.data[2] = cmd_class;
         burst.data[3] = command_code;
         burst.data[4] = LEN_HIGH_BYTE;
         burst.data[5] = payload_len;
         burst.data[6] = hdr_sum_a;
         burst.data[7] = hdr_sum_b;
         burst.ends[HDR_LEN-1] = (payload_len == 8'd0);
         burst.count = COUNT_W'(HDR_LEN);
         state_next.in_payload      = (payload_len != 8'd0);
         state_next.bytes_remaining = payload_len;
         state_next.sum_low         = 8'd0;
         state_next.sum_high        = 8'd0;
      end else if (state_cur.in_payload) begin
         burst.data[0] = payload_byte;
         state_next.bytes_remaining = remaining_dec;
         if (remaining_dec == 8'd0) begin
            // Last payload byte: the two payload sums close the frame.
            burst.data[1] = pay_sum_low;
            burst.data[2] = pay_sum_high;
            burst.ends[2] = 1'b1;
            burst.count   = COUNT_W'(3);
            state_next.in_payload = 1'b0;
            state_next.sum_low    = 8'd0;
            state_next.sum_high   = 8'd0;
         end else begin
            burst.count = COUNT_W'(1);
            state_next.sum_low  = pay_sum_low;
            state_next.sum_high = pay_sum_high;
         end
      end
   end

endmodule

// ===== sv/command_frame_builder_fletcher8_core.sv =====
// ----------------------------------------------------------------------------
// command_frame_builder_fletcher8_core
// Serializes command frames with Fletcher-8 header and payload sums.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake      | Contents
//  req_     | in        | valid / stall  | func, header fields, payload byte
//  rsp_     | out       | valid / stall  | out_byte, frame_end
//  csr_     | in        | valid / ready  | register index, write data
//
// A request is encoded in the cycle it is accepted into an eight-byte output
// shift register, which sends one byte per cycle while rsp_stall is low.
// Payload requests before the last stream at one per cycle likewise; a start
// request fills all eight bytes. A request is taken when the buffer is empty
// or as its last buffered byte is being delivered. Reset is synchronous and
// clears the frame state, byte count and end flags, not the buffered data.
// ----------------------------------------------------------------------------
`include "command_frame_builder_fletcher8_core_macros.svh"

module command_frame_builder_fletcher8_core import cfbf8_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_func,
   input  logic [7:0]             req_cmd_class,
   input  logic [7:0]             req_command_code,
   input  logic [7:0]             req_payload_len,
   input  logic [7:0]             req_payload_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_frame_end,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   frame_state_type         state_ff, state_in, state_calc;
   burst_type               burst;
   logic [HDR_LEN-1:0][7:0] data_ff, data_in;
   logic [HDR_LEN-1:0]      ends_ff, ends_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [7:0]              sync_first_ff, sync_first_in;
   logic [7:0]              sync_second_ff, sync_second_in;
   logic                    req_take;
   logic                    rsp_take;

   cfbf8_encode u_encode (
      .func         (req_func),
      .cmd_class    (req_cmd_class),
      .command_code (req_command_code),
      .payload_len  (req_payload_len),
      .payload_byte (req_payload_byte),
      .sync_first   (sync_first_ff),
      .sync_second  (sync_second_ff),
      .state_cur    (state_ff),
      .state_next   (state_calc),
      .burst        (burst)
   );

   assign rsp_valid     = (count_ff != '0);
   assign rsp_out_byte  = data_ff[0];
   assign rsp_frame_end = ends_ff[0];
   assign rsp_take      = rsp_valid && !rsp_stall;

   assign req_stall = !((count_ff == '0) || ((count_ff == COUNT_W'(1)) && rsp_take));
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      data_in  = data_ff;
      ends_in  = ends_ff;
      count_in = count_ff;
      if (req_take) begin
         state_in = state_calc;
         data_in  = burst.data;
         ends_in  = burst.ends;
         count_in = burst.count;
      end else if (rsp_take) begin
         data_in  = data_ff >> 8;
         ends_in  = ends_ff >> 1;
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SYNC_FIRST:  sync_first_in  = csr_wdata;
            CSR_SYNC_SECOND: sync_second_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= '0;
         count_ff       <= '0;
         ends_ff        <= '0;
         sync_first_ff  <= SYNC_FIRST_RESET;
         sync_second_ff <= SYNC_SECOND_RESET;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         ends_ff        <= ends_in;
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   `CFBF8_ASSERT_NOW(a_idle_takes_request, !rsp_valid, !req_stall)
   `CFBF8_ASSERT_NEXT(a_start_fills_header, req_take && (req_func == FUNC_START), count_ff == COUNT_W'(HDR_LEN))
   `CFBF8_ASSERT_NOW(a_end_is_last_byte, rsp_valid && rsp_frame_end, count_ff == COUNT_W'(1))
   `CFBF8_ASSERT_NOW(a_payload_tracks_count, 1'b1, state_ff.in_payload == (state_ff.bytes_remaining != 8'd0))

endmodule
